// ===== hdl/vrbf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrbf_pkg
// Shared types and register numbers for the video RAM block fill/copy unit.
// ----------------------------------------------------------------------------
package vrbf_pkg;

    localparam logic [1:0] CMD_WR_INDEX = 2'd0;
    localparam logic [1:0] CMD_WR_DATA  = 2'd1;
    localparam logic [1:0] CMD_RD_DATA  = 2'd2;
    localparam logic [1:0] CMD_RD_STAT  = 2'd3;

    localparam logic [5:0] REG_UPD_HI = 6'd18;
    localparam logic [5:0] REG_UPD_LO = 6'd19;
    localparam logic [5:0] REG_CTRL   = 6'd24;
    localparam logic [5:0] REG_COUNT  = 6'd30;
    localparam logic [5:0] REG_DATA   = 6'd31;
    localparam logic [5:0] REG_SRC_HI = 6'd32;
    localparam logic [5:0] REG_SRC_LO = 6'd33;

    localparam logic [7:0] READY_BIT = 8'h80;
    localparam int         COPY_BIT  = 7;

    // one classified host transaction passed from front to back
    typedef struct packed {
        logic [1:0] cmd;
        logic [5:0] sel;
        logic [7:0] value;
    } t_txn;

endpackage

// ===== hdl/vrbf_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrbf_ram
// Generic single-port RAM, registered read.
// ----------------------------------------------------------------------------
module vrbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== hdl/vrbf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrbf_front
// Accepts host transactions, tracks the index register, pushes a two-entry
// queue toward the back end.
// ----------------------------------------------------------------------------
module vrbf_front
    import vrbf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [1:0] i_command,
    input  logic [7:0] i_write_value,
    input  logic       i_pop,
    output logic       o_full,
    output logic       o_avail,
    output t_txn       o_txn
);
    logic [5:0] r_sel;
    t_txn       r_q [2];
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    t_txn       w_in;

    assign w_in    = '{cmd: i_command, sel: r_sel, value: i_write_value};
    assign o_full  = (r_cnt == 2'd2);
    assign o_avail = (r_cnt != 2'd0);
    assign o_txn   = r_q[0];

    always_comb begin
        n_cnt = r_cnt + {1'b0, i_take} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_take && i_command == CMD_WR_INDEX) begin
                r_sel <= i_write_value[5:0];
            end
        end
        // head slot: new entry lands here when the queue is (or becomes) empty
        if (i_take && (r_cnt == 2'd0 || (r_cnt == 2'd1 && i_pop))) begin
            r_q[0] <= w_in;
        end else if (i_pop) begin
            r_q[0] <= r_q[1];
        end
        if (i_take && r_cnt != 2'd0 && !(r_cnt == 2'd1 && i_pop)) begin
            r_q[1] <= w_in;
        end
    end
endmodule

// ===== hdl/vrbf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrbf_back
// Executes queued transactions: register file, memory port, block sequencer.
// ----------------------------------------------------------------------------
module vrbf_back
    import vrbf_pkg::*;
#(
    parameter int MEM_BYTES = 16384
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_avail,
    input  t_txn       i_txn,
    output logic       o_pop,
    output logic       o_idle,
    output logic       o_strobe,
    output logic [7:0] o_read_value
);
    localparam int AW = $clog2(MEM_BYTES);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_RDMEM = 6'b000010,
        ST_RDOUT = 6'b000100,
        ST_BRD   = 6'b001000,
        ST_BWAIT = 6'b010000,
        ST_BWR   = 6'b100000
    } t_state;

    t_state     r_state, n_state;
    logic [7:0] r_rf [64];
    logic [8:0] r_left;
    logic [15:0] r_dst, r_src;
    logic        r_copy;
    logic        r_strobe;
    logic [7:0]  r_out;

    logic          w_we;
    logic [AW-1:0] w_addr;
    logic [7:0]    w_wdata, w_rdata;
    logic [15:0]   w_upd;

    assign w_upd = {r_rf[REG_UPD_HI], r_rf[REG_UPD_LO]};

    vrbf_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_addr (w_addr),
        .i_wdata(w_wdata),
        .o_rdata(w_rdata)
    );

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        w_we    = 1'b0;
        w_addr  = w_upd[AW-1:0];
        w_wdata = i_txn.value;
        unique case (r_state)
            ST_IDLE: begin
                if (i_avail) begin
                    o_pop = 1'b1;
                    if (i_txn.cmd == CMD_WR_DATA && i_txn.sel == REG_DATA) begin
                        w_we = 1'b1;
                    end else if (i_txn.cmd == CMD_WR_DATA && i_txn.sel == REG_COUNT) begin
                        n_state = r_rf[REG_CTRL][COPY_BIT] ? ST_BRD : ST_BWR;
                    end else if (i_txn.cmd == CMD_RD_DATA && i_txn.sel == REG_DATA) begin
                        n_state = ST_RDMEM;
                    end
                end
            end
            ST_RDMEM: n_state = ST_RDOUT;
            ST_RDOUT: n_state = ST_IDLE;
            ST_BRD: begin
                w_addr  = r_src[AW-1:0];
                n_state = ST_BWAIT;
            end
            ST_BWAIT: begin
                // hold the source address so the read data stays put
                w_addr  = r_src[AW-1:0];
                n_state = ST_BWR;
            end
            ST_BWR: begin
                w_we    = 1'b1;
                w_addr  = r_dst[AW-1:0];
                w_wdata = r_copy ? w_rdata : r_rf[REG_DATA];
                if (r_left == 9'd1) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = r_copy ? ST_BRD : ST_BWR;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_idle       = (r_state == ST_IDLE);
    assign o_strobe     = r_strobe;
    assign o_read_value = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
            for (int k = 0; k < 64; k++) begin
                r_rf[k] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_strobe <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_avail) begin
                        r_out    <= '0;
                        r_strobe <= !(i_txn.cmd == CMD_RD_DATA && i_txn.sel == REG_DATA);
                        unique case (i_txn.cmd)
                            CMD_WR_INDEX: ;
                            CMD_WR_DATA: begin
                                r_rf[i_txn.sel] <= i_txn.value;
                                if (i_txn.sel == REG_DATA) begin
                                    {r_rf[REG_UPD_HI], r_rf[REG_UPD_LO]} <= w_upd + 16'd1;
                                end
                                r_left <= (i_txn.value == 8'd0) ? 9'd256 : {1'b0, i_txn.value};
                                r_dst  <= w_upd;
                                r_src  <= {r_rf[REG_SRC_HI], r_rf[REG_SRC_LO]};
                                r_copy <= r_rf[REG_CTRL][COPY_BIT];
                            end
                            CMD_RD_DATA: begin
                                r_out <= r_rf[i_txn.sel];
                                if (i_txn.sel == REG_DATA) begin
                                    {r_rf[REG_UPD_HI], r_rf[REG_UPD_LO]} <= w_upd + 16'd1;
                                end
                            end
                            CMD_RD_STAT: r_out <= READY_BIT;
                            default: ;
                        endcase
                    end
                end
                // RAM data for the old update address is valid this cycle only
                ST_RDMEM: r_out <= w_rdata;
                ST_RDOUT: r_strobe <= 1'b1;
                ST_BWR: begin
                    r_left <= r_left - 9'd1;
                    r_dst  <= r_dst + 16'd1;
                    if (r_copy) begin
                        r_src <= r_src + 16'd1;
                    end
                    if (r_left == 9'd1) begin
                        {r_rf[REG_UPD_HI], r_rf[REG_UPD_LO]} <= r_dst + 16'd1;
                        if (r_copy) begin
                            {r_rf[REG_SRC_HI], r_rf[REG_SRC_LO]} <= r_src + 16'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

// ===== hdl/video_ram_block_fill_copy_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_ram_block_fill_copy_unit
// Index/data register pair over a byte-wide video RAM with block fill/copy.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake           Payload
// host cmd  in   start / busy        i_command, i_write_value
// result    out  o_valid (strobe)    o_read_value
//
// Each transaction yields one result; a memory read waits on the registered
// RAM read. A block operation (fill, or copy: read, wait, write on the
// single RAM port) occupies the back end for N bytes, N = 1..256; the status
// answer always reports ready. Reset clears the index, register file and
// queue; RAM contents are undefined until written. The receiver cannot
// stall results.
// ----------------------------------------------------------------------------
module video_ram_block_fill_copy_unit
    import vrbf_pkg::*;
#(
    parameter int VIDEO_MEMORY_BYTES = 16384
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_command,
    input  logic [7:0] i_write_value,
    output logic       o_valid,
    output logic [7:0] o_read_value
);
    logic w_full, w_avail, w_pop, w_idle, w_take;
    t_txn w_txn;

    // the queue absorbs a transaction while the back end runs a block
    assign busy   = w_full;
    assign w_take = start && !busy;

    vrbf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (w_take),
        .i_command    (i_command),
        .i_write_value(i_write_value),
        .i_pop        (w_pop),
        .o_full       (w_full),
        .o_avail      (w_avail),
        .o_txn        (w_txn)
    );

    vrbf_back #(.MEM_BYTES(VIDEO_MEMORY_BYTES)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_avail     (w_avail),
        .i_txn       (w_txn),
        .o_pop       (w_pop),
        .o_idle      (w_idle),
        .o_strobe    (o_valid),
        .o_read_value(o_read_value)
    );

    // pops only happen from an idle back end with work queued
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> (w_idle && w_avail)) else $error("pop while back end active");

    // a transaction is never taken into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |-> !w_take) else $error("queue overflow");

    // a result strobe lasts a single cycle unless the back end was idle
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(o_valid)) |-> $past(w_idle)) else $error("stray result strobe");
endmodule
